FILE: hdl/hmq_pkg.sv
// hmq_pkg: shared constants and codes for the binary min-heap queue
// no dependencies; imported by hmq_heap_ram, binary_min_heap_queue and the testbench
`default_nettype none

package hmq_pkg;

    localparam int HEAP_DEPTH_DEF = 32;
    localparam int KEY_BITS_DEF   = 16;
    localparam int TAG_BITS_DEF   = 8;
    localparam int OCC_BITS       = 6;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

endpackage

`default_nettype wire

FILE: hdl/binary_min_heap_queue.sv
// binary_min_heap_queue: top level of the min-heap priority queue
// depends on hmq_pkg and hmq_heap_ram
//
// usage:
//   input channel (in_valid / in_stall) carries one word: func, new_key, new_tag.
//   func insert places the entry in the heap; func remove pops the minimum key.
//   output channel (out_valid / out_stall) returns one word per input word:
//   out_key / out_tag of the removed entry (zero otherwise), status and the
//   occupancy after the operation.
// timing:
//   the block works on one word at a time; in_stall is high while busy.
//   a result is raised on out_valid from S_DONE, and the next word is taken
//   once the sequencer is back in S_IDLE.
//   insert: S_UP reads the parent and S_UP_CMP compares and writes, once per
//   heap level climbed; the climb ends at the root or below a smaller parent.
//   remove: S_RM_LOAD takes the root and the last entry, then S_DN and S_DN_CMP
//   run once per level descended, until a leaf or no smaller child.
//   refused operations (full insert, empty remove) go straight to S_DONE.
//   each sift level costs one registered read of the slot memory, one key
//   compare and one write; the way down also picks the smaller child.
// reset:
//   rst_n clears the entry count and the output valid; slot contents are
//   left as they are and never used before written.
// stall:
//   a finished result sits in the output register; the next input word is
//   taken meanwhile, and its result waits in the done state until released.
`default_nettype none

module binary_min_heap_queue
    import hmq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                func,
    input  wire logic [KEY_BITS-1:0] new_key,
    input  wire logic [TAG_BITS-1:0] new_tag,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [KEY_BITS-1:0] out_key,
    output logic      [TAG_BITS-1:0] out_tag,
    output logic      [1:0]          status,
    output logic      [OCC_BITS-1:0] occupancy
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = AW + 2;
    localparam int EW = KEY_BITS + TAG_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_RM_LOAD,
        S_DN,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [TAG_BITS-1:0] cur_tag_reg, cur_tag_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;
    logic [TAG_BITS-1:0] res_tag_reg, res_tag_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic [TAG_BITS-1:0] out_tag_reg, out_tag_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [OCC_BITS-1:0] out_occ_reg, out_occ_next;

    // memory ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_a_addr, rd_b_addr;
    logic [EW-1:0] rd_a_data, rd_b_data;

    // child and parent index arithmetic
    logic [IW-1:0]       left_idx, right_idx, count_ext;
    logic [AW-1:0]       parent_addr;
    logic                have_left, have_right;
    logic [KEY_BITS-1:0] a_key, b_key, pick_key;
    logic [TAG_BITS-1:0] a_tag, b_tag, pick_tag;
    logic [AW-1:0]       pick_addr;
    logic                take_right;

    hmq_heap_ram #(
        .DEPTH (HEAP_DEPTH),
        .WIDTH (EW),
        .AW    (AW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    assign left_idx    = IW'({pos_reg, 1'b1});
    assign right_idx   = left_idx + IW'(1);
    assign count_ext   = IW'(count_reg);
    assign parent_addr = AW'((pos_reg - AW'(1)) >> 1);
    assign have_left   = left_idx < count_ext;
    assign have_right  = right_idx < count_ext;

    assign a_key = rd_a_data[EW-1:TAG_BITS];
    assign a_tag = rd_a_data[TAG_BITS-1:0];
    assign b_key = rd_b_data[EW-1:TAG_BITS];
    assign b_tag = rd_b_data[TAG_BITS-1:0];

    // smaller child, right one on a tie
    assign take_right = have_right && !(a_key < b_key);
    assign pick_key   = take_right ? b_key : a_key;
    assign pick_tag   = take_right ? b_tag : a_tag;
    assign pick_addr  = take_right ? AW'(right_idx) : AW'(left_idx);

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        cur_key_next    = cur_key_reg;
        cur_tag_next    = cur_tag_reg;
        res_key_next    = res_key_reg;
        res_tag_next    = res_tag_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_key_next    = out_key_reg;
        out_tag_next    = out_tag_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;

        wr_en     = 1'b0;
        wr_addr   = pos_reg;
        wr_data   = {cur_key_reg, cur_tag_reg};
        rd_a_addr = AW'(left_idx);
        rd_b_addr = AW'(right_idx);

        // output register drains independently of the sequencer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_a_addr = '0;
                rd_b_addr = AW'(count_reg - CW'(1));
                if (in_valid)
                begin
                    res_key_next    = '0;
                    res_tag_next    = '0;
                    res_status_next = STATUS_OK;
                    cur_key_next    = new_key;
                    cur_tag_next    = new_tag;
                    if (func == FUNC_INSERT)
                    begin
                        if (count_reg == CW'(HEAP_DEPTH))
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            state_next = S_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_RM_LOAD;
                        end
                    end
                end
            end

            S_UP:
            begin
                rd_a_addr = parent_addr;
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (cur_key_reg > a_key)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // parent moves down into the hole
                    wr_data    = rd_a_data;
                    pos_next   = parent_addr;
                    state_next = S_UP;
                end
            end

            S_RM_LOAD:
            begin
                res_key_next = a_key;
                res_tag_next = a_tag;
                cur_key_next = b_key;
                cur_tag_next = b_tag;
                pos_next     = '0;
                state_next   = S_DN;
            end

            S_DN:
            begin
                if (!have_left)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (pick_key < cur_key_reg)
                begin
                    // child moves up into the hole
                    wr_data    = {pick_key, pick_tag};
                    pos_next   = pick_addr;
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = res_key_reg;
                    out_tag_next    = res_tag_reg;
                    out_status_next = res_status_reg;
                    out_occ_next    = OCC_BITS'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pos_reg        <= '0;
            cur_key_reg    <= '0;
            cur_tag_reg    <= '0;
            res_key_reg    <= '0;
            res_tag_reg    <= '0;
            res_status_reg <= STATUS_OK;
            out_key_reg    <= '0;
            out_tag_reg    <= '0;
            out_status_reg <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            pos_reg        <= pos_next;
            cur_key_reg    <= cur_key_next;
            cur_tag_reg    <= cur_tag_next;
            res_key_reg    <= res_key_next;
            res_tag_reg    <= res_tag_next;
            res_status_reg <= res_status_next;
            out_key_reg    <= out_key_next;
            out_tag_reg    <= out_tag_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_tag   = out_tag_reg;
    assign status    = out_status_reg;
    assign occupancy = out_occ_reg;

endmodule

`default_nettype wire

FILE: hdl/hmq_heap_ram.sv
// hmq_heap_ram: heap slot storage, one write port and two registered read ports
// depends on hmq_pkg for default sizes
`default_nettype none

module hmq_heap_ram
    import hmq_pkg::*;
#(
    parameter int DEPTH = HEAP_DEPTH_DEF,
    parameter int WIDTH = KEY_BITS_DEF + TAG_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_a_addr,
    output logic      [WIDTH-1:0] rd_a_data,
    input  wire logic [AW-1:0]    rd_b_addr,
    output logic      [WIDTH-1:0] rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // out-of-range addresses only occur for slots whose data is ignored
    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_binary_min_heap_queue.sv
// tb_binary_min_heap_queue: self-checking testbench for the min-heap priority queue
// depends on hmq_pkg and binary_min_heap_queue; keeps its own heap mirror for prediction
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
    import hmq_pkg::*;

    localparam int DEPTH      = HEAP_DEPTH_DEF;
    localparam int KEY_W      = KEY_BITS_DEF;
    localparam int TAG_W      = TAG_BITS_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int TAIL_WAIT  = 30;

    // one result word as the block should return it
    typedef struct {
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        status_t             stat;
        logic [OCC_BITS-1:0] occ;
    } heap_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                func = 1'b0;
    logic [KEY_W-1:0]    new_key = '0;
    logic [TAG_W-1:0]    new_tag = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KEY_W-1:0]    out_key;
    logic [TAG_W-1:0]    out_tag;
    logic [1:0]          status;
    logic [OCC_BITS-1:0] occupancy;

    // heap mirror: only slots that hold entries are ever read
    logic [KEY_W-1:0]    mirror_keys [DEPTH];
    logic [TAG_W-1:0]    mirror_tags [DEPTH];
    int                  mirror_count = 0;

    heap_reply_t         heap_replies [$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;

    binary_min_heap_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .new_key   (new_key),
        .new_tag   (new_tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_key   (out_key),
        .out_tag   (out_tag),
        .status    (status),
        .occupancy (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void swap_mirror(int a, int b);
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        k = mirror_keys[a];
        t = mirror_tags[a];
        mirror_keys[a] = mirror_keys[b];
        mirror_tags[a] = mirror_tags[b];
        mirror_keys[b] = k;
        mirror_tags[b] = t;
    endfunction

    // applies one word to the mirror and returns the reply it must produce
    function automatic heap_reply_t heap_apply(func_t op, logic [KEY_W-1:0] key,
                                               logic [TAG_W-1:0] tag);
        heap_reply_t r;
        int pos;
        int parent;
        int left;
        int right;
        int pick;
        bit done;
        r.key  = '0;
        r.tag  = '0;
        r.stat = STATUS_OK;
        if (op == FUNC_INSERT) begin
            if (mirror_count >= DEPTH) begin
                r.stat = STATUS_FULL;
            end
            else begin
                mirror_keys[mirror_count] = key;
                mirror_tags[mirror_count] = tag;
                pos = mirror_count;
                mirror_count++;
                // climb while not above the parent, so equal keys move up
                done = 1'b0;
                while (pos > 0 && !done) begin
                    parent = (pos - 1) / 2;
                    if (mirror_keys[pos] > mirror_keys[parent])
                        done = 1'b1;
                    else begin
                        swap_mirror(pos, parent);
                        pos = parent;
                    end
                end
            end
        end
        else begin
            if (mirror_count == 0) begin
                r.stat = STATUS_EMPTY;
            end
            else begin
                r.key = mirror_keys[0];
                r.tag = mirror_tags[0];
                mirror_count--;
                mirror_keys[0] = mirror_keys[mirror_count];
                mirror_tags[0] = mirror_tags[mirror_count];
                // descend: smaller child, right one on a tie, strict compare to swap
                pos  = 0;
                done = 1'b0;
                while (!done) begin
                    left  = 2 * pos + 1;
                    right = left + 1;
                    if (left >= mirror_count)
                        done = 1'b1;
                    else begin
                        pick = left;
                        if (right < mirror_count && !(mirror_keys[left] < mirror_keys[right]))
                            pick = right;
                        if (!(mirror_keys[pick] < mirror_keys[pos]))
                            done = 1'b1;
                        else begin
                            swap_mirror(pos, pick);
                            pos = pick;
                        end
                    end
                end
            end
        end
        r.occ = mirror_count[OCC_BITS-1:0];
        return r;
    endfunction

    // drives one word after a random gap and holds it until taken
    task automatic send_word(input func_t op, input logic [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag);
        heap_reply_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        new_key  <= key;
        new_tag  <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = heap_apply(op, key, tag);
        heap_replies.push_back(want);
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare every taken result word with the oldest prediction
    always @(posedge clk)
    begin
        heap_reply_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (heap_replies.size() == 0) begin
                $error("result word with nothing expected: key %h tag %h status %0d occ %0d",
                       out_key, out_tag, status, occupancy);
                error_count++;
            end
            else begin
                want = heap_replies.pop_front();
                if (out_key !== want.key) begin
                    $error("out_key expected %h got %h", want.key, out_key);
                    error_count++;
                end
                if (out_tag !== want.tag) begin
                    $error("out_tag expected %h got %h", want.tag, out_tag);
                    error_count++;
                end
                if (status !== want.stat) begin
                    $error("status expected %0d got %0d", want.stat, status);
                    error_count++;
                end
                if (occupancy !== want.occ) begin
                    $error("occupancy expected %0d got %0d", want.occ, occupancy);
                    error_count++;
                end
            end
        end
    end

    // watchdog: far above the slowest legal run
    initial
    begin
        while (cycle_count < CYCLE_CAP) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // remove twice from an empty heap, before any traffic
    task automatic test_empty_remove();
        send_word(FUNC_REMOVE, 16'hA5A5, 8'h5A);
        send_word(FUNC_REMOVE, '1, '1);
    endtask

    // extreme keys and tags go in and come back out in order, then one more remove finds the heap empty
    task automatic test_key_extremes();
        send_word(FUNC_INSERT, '1, '1);
        send_word(FUNC_INSERT, '0, '0);
        send_word(FUNC_REMOVE, '0, '0);
        send_word(FUNC_REMOVE, '1, '1);
        send_word(FUNC_REMOVE, '0, '0);
    endtask

    // a new entry climbs above a parent with the same key
    task automatic test_equal_key_climb();
        send_word(FUNC_INSERT, 16'h1234, 8'h11);
        send_word(FUNC_INSERT, 16'h1234, 8'h22);
        send_word(FUNC_INSERT, 16'h1234, 8'h33);
        send_word(FUNC_REMOVE, '0, '0);
        send_word(FUNC_REMOVE, '0, '0);
        send_word(FUNC_REMOVE, '0, '0);
    endtask

    // equal children on the way down: the right one wins, then a lone left child
    task automatic test_child_tie();
        send_word(FUNC_INSERT, 16'd10, 8'h01);
        send_word(FUNC_INSERT, 16'd20, 8'h02);
        send_word(FUNC_INSERT, 16'd20, 8'h03);
        send_word(FUNC_INSERT, 16'd30, 8'h04);
        send_word(FUNC_REMOVE, '0, '0);
        send_word(FUNC_REMOVE, '0, '0);
        send_word(FUNC_REMOVE, '0, '0);
        send_word(FUNC_REMOVE, '0, '0);
    endtask

    // random traffic in segments that lean to fill, churn or drain the heap,
    // so full and empty refusals come up often; narrow keys force ties
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_words);
        int               ins_pct;
        int               i;
        func_t            op;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        ins_pct = 90;
        for (i = 0; i < n_words; i++) begin
            if (i != 0 && i % 40 == 0) begin
                case ($urandom_range(2))
                    0:       ins_pct = 90;
                    1:       ins_pct = 50;
                    default: ins_pct = 10;
                endcase
            end
            op = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
            case ($urandom_range(3))
                0:       key = KEY_W'($urandom_range(7));
                1:       key = $urandom_range(1) ? '1 : '0;
                default: key = KEY_W'($urandom_range(16'hFFFF));
            endcase
            tag = TAG_W'($urandom_range(255));
            send_word(op, key, tag);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_remove();
        test_key_extremes();
        test_equal_key_climb();
        test_child_tie();

        test_random_traffic(0, 0, 320);
        test_random_traffic(84, 0, 320);
        test_random_traffic(0, 84, 320);
        test_random_traffic(31, 31, 320);

        in_valid <= 1'b0;
        while (heap_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
hdl/hmq_pkg.sv
hdl/hmq_heap_ram.sv
hdl/binary_min_heap_queue.sv
tb/sv/tb_binary_min_heap_queue.sv
